>>> hdl/assert_macros.svh
// Assertion macros used by the top level to check block behavior.
// Depends on nothing; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("assertion failed: forbidden condition");

// a at a clock edge implies b at the same edge
`define ASSERT_IMPLIES(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("assertion failed: implication");

// a at a clock edge implies b at the next edge
`define ASSERT_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/wal_pkg.sv
// Types, codes and helpers for the antialiased line rasterizer.
// Depends on nothing; used by the queue, front, back and top level.
package wal_pkg;

  localparam int CRD_W       = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LUMA_W      = 18;
  localparam int LUMA_R      = 299;
  localparam int LUMA_G      = 587;
  localparam int LUMA_B      = 114;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_LINE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_NOP,
    OP_PLAIN,
    OP_STEEP,
    OP_SHALLOW
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PRES,
    S_PLAIN,
    S_DIV,
    S_STEP,
    S_RD,
    S_WT,
    S_MUL,
    S_WR,
    S_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic signed [CRD_W-1:0] x0;
    logic signed [CRD_W-1:0] y0;
    logic signed [CRD_W-1:0] x1;
    logic signed [CRD_W-1:0] y1;
    logic                    neg;
    logic                    sx_en;
    logic                    sy_en;
    logic [11:0]             major;
    logic [11:0]             minor;
    logic [23:0]             rgb;
    logic [LUMA_W-1:0]       luma;
  } cmd_t;

  function automatic logic [LUMA_W-1:0] luma_of(logic [23:0] c);
    return LUMA_W'(LUMA_R * int'(c[23:16]) + LUMA_G * int'(c[15:8])
                   + LUMA_B * int'(c[7:0]));
  endfunction

endpackage

>>> hdl/wal_cmd_if.sv
// Command channel: valid/ready handshake with the command payload.
// Depends on nothing.
interface wal_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [11:0] xa;
  logic signed [11:0] ya;
  logic signed [11:0] xb;
  logic signed [11:0] yb;
  logic [23:0]        rgb;

  modport source(output valid, kind, xa, ya, xb, yb, rgb, input ready);
  modport sink(input valid, kind, xa, ya, xb, yb, rgb, output ready);
endinterface

>>> hdl/wal_res_if.sv
// Result channel: valid/ready handshake with the result payload.
// Depends on nothing.
interface wal_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] read_rgb;
  logic        off_frame;

  modport source(output valid, read_rgb, off_frame, input ready);
  modport sink(input valid, read_rgb, off_frame, output ready);
endinterface

>>> hdl/antialiased_line_raster.sv
// Antialiased line rasterizer over a FRAME_W x FRAME_H RGB frame store: each
// command writes a pixel, reads one back, draws a Wu line or does nothing, and
// yields one result. A horizontal, vertical or diagonal line writes its pixels
// straight along the major axis; any other line first runs the slope divider,
// then blends two pixels per interior major-axis step (read, weight, multiply,
// write each) through the single-port frame store and writes the far end. A
// stalled result holds the walker until it is taken. Commands
// queue up to 4 deep ahead of the walker. The store holds garbage until
// written; reading an unwritten pixel returns undefined data.
// Depends on wal_pkg, wal_cmd_if, wal_res_if, wal_queue, wal_front, wal_back.
`include "assert_macros.svh"

module antialiased_line_raster #(
  parameter int FRAME_W = 256,
  parameter int FRAME_H = 256
) (
  input  logic      clk,
  input  logic      rst,
  wal_cmd_if.sink   cmd,
  wal_res_if.source res
);
  import wal_pkg::*;

  logic push, full, pop, nonempty;
  cmd_t push_data, pop_data;

  wal_front u_front (
    .cmd       (cmd),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  wal_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_data  (pop_data)
  );

  wal_back #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .pop_data (pop_data),
    .pop      (pop),
    .res      (res)
  );

  `ASSERT_NEVER(a_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && !nonempty)
  `ASSERT_IMPLIES(a_off_value, clk, rst, res.valid && res.off_frame, res.read_rgb == 24'hFFFFFF || res.read_rgb == 24'h0)
  `ASSERT_NEXT(a_push_fill, clk, rst, push && !pop, nonempty)
endmodule

>>> hdl/wal_queue.sv
// Short FIFO of classified commands between front and back.
// Depends on wal_pkg.
module wal_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wal_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output wal_pkg::cmd_t pop_data
);
  import wal_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

>>> hdl/wal_front.sv
// Front end: accepts commands, orders line endpoints and classifies lines.
// Depends on wal_pkg and wal_cmd_if.
module wal_front (
  wal_cmd_if.sink       cmd,
  input  logic          full,
  output logic          push,
  output wal_pkg::cmd_t push_data
);
  import wal_pkg::*;

  logic                    swap;
  logic signed [CRD_W-1:0] x0, y0, x1, y1, dxs, dys, adx13;
  logic [11:0]             adx, ady;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  always_comb begin
    swap  = (cmd.kind == KIND_LINE) && (cmd.ya > cmd.yb);
    x0    = CRD_W'(swap ? cmd.xb : cmd.xa);
    y0    = CRD_W'(swap ? cmd.yb : cmd.ya);
    x1    = CRD_W'(swap ? cmd.xa : cmd.xb);
    y1    = CRD_W'(swap ? cmd.ya : cmd.yb);
    dxs   = x1 - x0;
    dys   = y1 - y0;
    adx13 = dxs[CRD_W-1] ? -dxs : dxs;
    adx   = adx13[11:0];
    ady   = dys[11:0];

    push_data.x0    = x0;
    push_data.y0    = y0;
    push_data.x1    = x1;
    push_data.y1    = y1;
    push_data.neg   = dxs[CRD_W-1];
    push_data.sx_en = (adx != '0);
    push_data.sy_en = (ady != '0);
    push_data.rgb   = cmd.rgb;
    push_data.luma  = luma_of(cmd.rgb);
    push_data.major = (ady > adx) ? ady : adx;
    push_data.minor = (ady > adx) ? adx : ady;

    unique case (cmd.kind)
      KIND_WRITE: push_data.op = OP_WRITE;
      KIND_READ:  push_data.op = OP_READ;
      KIND_LINE: begin
        if (ady == '0 || adx == '0 || adx == ady) push_data.op = OP_PLAIN;
        else if (ady > adx) push_data.op = OP_STEEP;
        else push_data.op = OP_SHALLOW;
      end
      default:    push_data.op = OP_NOP;
    endcase
  end
endmodule

>>> hdl/wal_back.sv
// Back end: frame store, line walker, slope divider and pixel blender.
// Depends on wal_pkg and wal_res_if.
module wal_back #(
  parameter int FRAME_W = 256,
  parameter int FRAME_H = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          nonempty,
  input  wal_pkg::cmd_t pop_data,
  output logic          pop,
  wal_res_if.source     res
);
  import wal_pkg::*;

  localparam int XW    = (FRAME_W > 1) ? $clog2(FRAME_W) : 1;
  localparam int YW    = (FRAME_H > 1) ? $clog2(FRAME_H) : 1;
  localparam int AW    = XW + YW;
  localparam logic signed [CRD_W-1:0] W_LIM = CRD_W'(FRAME_W);
  localparam logic signed [CRD_W-1:0] H_LIM = CRD_W'(FRAME_H);

  state_t state, state_next;
  cmd_t   cmd;

  logic signed [CRD_W-1:0] cx, cy, tx, ty, stepx;
  logic [11:0]    cnt;
  logic [15:0]    acc, adj;
  logic [11:0]    rem;
  logic [3:0]     dcnt;
  logic           side;
  logic           tin, we;
  logic [AW-1:0]  taddr;
  logic [23:0]    wdata, rdata, bg, bg_now, blend_px;
  logic [7:0]     wt, w;
  logic [7:0]     mn  [3];
  logic [15:0]    prod [3];
  logic [23:0]    res_rgb;
  logic           res_off;
  logic [23:0]    mem [2**AW];
  logic [12:0]    r2;
  logic [16:0]    acc_sum;
  logic           lighter;

  assign stepx = cmd.neg ? -CRD_W'(1) : CRD_W'(1);
  assign w     = acc[15:8];

  // target pixel of this cycle
  always_comb begin
    tx = cx;
    ty = cy;
    unique case (state)
      S_START: begin
        tx = cmd.x0;
        ty = cmd.y0;
      end
      S_PLAIN: begin
        tx = cmd.sx_en ? cx + stepx : cx;
        ty = cmd.sy_en ? cy + CRD_W'(1) : cy;
      end
      S_LAST: begin
        tx = cmd.x1;
        ty = cmd.y1;
      end
      default: begin
        if (side && cmd.op == OP_STEEP) tx = cx + stepx;
        if (side && cmd.op != OP_STEEP) ty = cy + CRD_W'(1);
      end
    endcase
    tin   = !tx[CRD_W-1] && (tx < W_LIM) && !ty[CRD_W-1] && (ty < H_LIM);
    taddr = {ty[YW-1:0], tx[XW-1:0]};
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [15:0] t;
      t = prod[c] + {8'd0, prod[c][15:8]} + 16'd1;
      blend_px[c*8 +: 8] = mn[c] + t[15:8];
    end
  end

  always_comb begin
    bg_now  = tin ? rdata : 24'hFFFFFF;
    lighter = cmd.luma < luma_of(bg_now);
    r2      = {rem, 1'b0};
    acc_sum = {1'b0, acc} + {1'b0, adj};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (nonempty) state_next = S_START;
      S_START: begin
        unique case (cmd.op)
          OP_READ:  state_next = S_PRES;
          OP_PLAIN: state_next = S_PLAIN;
          OP_STEEP, OP_SHALLOW: state_next = S_DIV;
          default:  state_next = S_DONE;
        endcase
      end
      S_PRES:  state_next = S_DONE;
      S_PLAIN: if (cnt == '0) state_next = S_DONE;
      S_DIV:   if (dcnt == 4'hF) state_next = S_STEP;
      S_STEP:  state_next = S_RD;
      S_RD:    state_next = S_WT;
      S_WT:    state_next = S_MUL;
      S_MUL:   state_next = S_WR;
      S_WR: begin
        if (!side) state_next = S_RD;
        else if (cnt == 12'd1) state_next = S_LAST;
        else state_next = S_STEP;
      end
      S_LAST:  state_next = S_DONE;
      S_DONE:  if (!res.valid || res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop   = (state == S_IDLE) && nonempty;
    wdata = (state == S_WR) ? blend_px : cmd.rgb;
    unique case (state)
      S_START: we = tin && (cmd.op == OP_WRITE || cmd.op == OP_PLAIN
                            || cmd.op == OP_STEEP || cmd.op == OP_SHALLOW);
      S_PLAIN: we = tin && (cnt != '0);
      S_WR, S_LAST: we = tin;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[taddr] <= wdata;
    rdata <= mem[taddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pop) cmd <= pop_data;
    unique case (state)
      S_START: begin
        cx      <= cmd.x0;
        cy      <= cmd.y0;
        acc     <= '0;
        adj     <= '0;
        rem     <= cmd.minor;
        dcnt    <= '0;
        side    <= 1'b0;
        cnt     <= (cmd.op == OP_PLAIN) ? cmd.major : cmd.major - 12'd1;
        res_rgb <= '0;
        res_off <= (cmd.op == OP_WRITE) && !tin;
      end
      S_PRES: begin
        res_rgb <= bg_now;
        res_off <= !tin;
      end
      S_PLAIN: begin
        if (cnt != '0) begin
          cx  <= tx;
          cy  <= ty;
          cnt <= cnt - 12'd1;
        end
      end
      S_DIV: begin
        dcnt <= dcnt + 4'd1;
        if (r2 >= {1'b0, cmd.major}) begin
          rem <= 12'(r2 - {1'b0, cmd.major});
          adj <= {adj[14:0], 1'b1};
        end else begin
          rem <= r2[11:0];
          adj <= {adj[14:0], 1'b0};
        end
      end
      S_STEP: begin
        acc  <= acc_sum[15:0];
        side <= 1'b0;
        if (cmd.op == OP_STEEP) begin
          cy <= cy + CRD_W'(1);
          if (acc_sum[16]) cx <= cx + stepx;
        end else begin
          cx <= cx + stepx;
          if (acc_sum[16]) cy <= cy + CRD_W'(1);
        end
      end
      S_WT: begin
        bg <= bg_now;
        if (side) wt <= lighter ? ~w : w;
        else wt <= lighter ? w : ~w;
      end
      S_MUL: begin
        for (int c = 0; c < 3; c++) begin
          logic [7:0] cb, cl;
          cb = bg[c*8 +: 8];
          cl = cmd.rgb[c*8 +: 8];
          mn[c]   <= (cb < cl) ? cb : cl;
          prod[c] <= wt * ((cb < cl) ? cl - cb : cb - cl);
        end
      end
      S_WR: begin
        if (!side) side <= 1'b1;
        else cnt <= cnt - 12'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == S_DONE && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res.valid || res.ready)) begin
      res.read_rgb  <= res_rgb;
      res.off_frame <= res_off;
    end
  end
endmodule
